// ----- design/gll_pkg.sv -----
// Shared constants, request codes and control/status types of the gated linear layer.
package gll_pkg;

  localparam int MAX_IN  = 64;
  localparam int MAX_OUT = 16;

  localparam int ROW_W   = 4;
  localparam int COL_W   = 6;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 40;
  localparam int NIN_W   = 7;
  localparam int NOUT_W  = 5;
  localparam int IDX_W   = 7;
  localparam int WADDR_W = ROW_W + COL_W;
  localparam int WDEPTH  = MAX_OUT * MAX_IN;

  localparam logic signed [VAL_W-1:0] WEIGHT_RESET   = 16'sd41;
  localparam logic signed [VAL_W-1:0] GATE_RESET     = 16'sd4096;
  localparam logic signed [VAL_W-1:0] GATE_THRESHOLD = 16'sd2048;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_GATE   = 2'd1;
  localparam logic [1:0] REQ_ELEM   = 2'd2;

  localparam logic REG_IN_FEATURES  = 1'b0;
  localparam logic REG_OUT_FEATURES = 1'b1;

  typedef struct packed {
    logic               clr_we;
    logic [WADDR_W-1:0] clr_addr;
    logic               wr_weight;
    logic               wr_gate;
    logic               load_x;
    logic               issue;
    logic [ROW_W-1:0]   issue_row;
    logic [COL_W-1:0]   issue_col;
    logic               emit_load;
    logic [ROW_W-1:0]   emit_row;
    logic               emit_last;
    logic               emit_status;
    logic               emit_final;
  } gll_cmd_t;

  typedef struct packed {
    logic s1_busy;
    logic pipe_busy;
    logic out_free;
  } gll_sts_t;

endpackage

// ----- design/gll_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gll_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/gll_ctrl.sv -----
// Controller: clearing pass, request decode, row sequencing and result emission.
module gll_ctrl import gll_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        req_type_i,
  input  logic              last_i,
  input  logic [NIN_W-1:0]  n_in_i,
  input  logic [NOUT_W-1:0] n_out_i,
  input  gll_sts_t          sts_i,
  output gll_cmd_t          cmd_o,
  output logic              in_stall_o
);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [WADDR_W-1:0] clr_q, clr_d;
  logic [ROW_W-1:0]   rc_q, rc_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               last_q, last_d;
  logic               status_q, status_d;
  logic [IDX_W-1:0]   idx_inc;
  logic [ROW_W-1:0]   last_row;
  logic               accept;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign last_row = ROW_W'(n_out_i - NOUT_W'(1));
  assign idx_inc  = (idx_q < IDX_W'(MAX_IN + 1)) ? idx_q + IDX_W'(1) : idx_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    rc_d     = rc_q;
    idx_d    = idx_q;
    col_d    = col_q;
    last_d   = last_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.clr_addr    = clr_q;
    cmd_o.issue_row   = rc_q;
    cmd_o.issue_col   = col_q;
    cmd_o.emit_row    = rc_q;
    cmd_o.emit_status = status_q;
    cmd_o.emit_last   = (rc_q == last_row);
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_we = 1'b1;
        clr_d = clr_q + WADDR_W'(1);
        if (clr_q == WADDR_W'(WDEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_WEIGHT: cmd_o.wr_weight = 1'b1;
            REQ_GATE:   cmd_o.wr_gate = 1'b1;
            REQ_ELEM: begin
              cmd_o.load_x = 1'b1;
              idx_d    = idx_inc;
              col_d    = idx_q[COL_W-1:0];
              last_d   = last_i;
              status_d = (idx_inc != n_in_i);
              rc_d     = '0;
              if (idx_q < n_in_i) begin
                state_d = ST_MAC;
              end else if (last_i) begin
                state_d = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        if (rc_q == last_row) begin
          state_d = ST_DRAIN;
        end else begin
          rc_d = rc_q + ROW_W'(1);
        end
      end
      ST_DRAIN: begin
        // the last product accumulates this cycle once stage one is empty
        if (!sts_i.s1_busy) begin
          rc_d    = '0;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (rc_q == last_row) begin
            cmd_o.emit_final = 1'b1;
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            rc_d = rc_q + ROW_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      clr_q    <= '0;
      rc_q     <= '0;
      idx_q    <= '0;
      col_q    <= '0;
      last_q   <= 1'b0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      rc_q     <= rc_d;
      idx_q    <= idx_d;
      col_q    <= col_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- design/gll_dp.sv -----
// Datapath: weight RAM, gates, multiply-accumulate pipeline, row sums and output register.
module gll_dp import gll_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gll_cmd_t                cmd_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [COL_W-1:0]        col_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    out_stall_i,
  output gll_sts_t                sts_o,
  output logic                    out_valid_o,
  output logic [ROW_W-1:0]        out_row_o,
  output logic signed [SUM_W-1:0] out_value_o,
  output logic                    out_last_o,
  output logic                    status_o
);

  logic signed [VAL_W-1:0]  x_q;
  logic signed [VAL_W-1:0]  gate_q [MAX_OUT];
  logic signed [SUM_W-1:0]  sum_q  [MAX_OUT];
  logic                     s1_vld_q, s2_vld_q;
  logic [ROW_W-1:0]         s1_row_q, s2_row_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     out_valid_q;
  logic [ROW_W-1:0]         out_row_q;
  logic signed [SUM_W-1:0]  out_value_q;
  logic                     out_last_q;
  logic                     status_q;

  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]   ram_wdata;
  logic [VAL_W-1:0]   ram_rdata;
  logic               acc_en;

  assign ram_we    = cmd_i.clr_we || cmd_i.wr_weight;
  assign ram_waddr = cmd_i.clr_we ? cmd_i.clr_addr : {row_i, col_i};
  assign ram_wdata = cmd_i.clr_we ? WEIGHT_RESET : value_i;

  gll_ram #(
    .WIDTH(VAL_W),
    .DEPTH(WDEPTH)
  ) u_wram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i({cmd_i.issue_row, cmd_i.issue_col}),
    .rdata_o(ram_rdata)
  );

  assign acc_en = s2_vld_q && (gate_q[s2_row_q] > GATE_THRESHOLD);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= value_i;
    end
    s1_row_q <= cmd_i.issue_row;
    s2_row_q <= s1_row_q;
    prod_q   <= $signed(ram_rdata) * x_q;
    if (cmd_i.emit_load) begin
      out_row_q   <= cmd_i.emit_row;
      out_value_q <= sum_q[cmd_i.emit_row];
      out_last_q  <= cmd_i.emit_last;
      status_q    <= cmd_i.emit_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < MAX_OUT; r++) begin
        gate_q[r] <= GATE_RESET;
        sum_q[r]  <= '0;
      end
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.wr_gate) begin
        gate_q[row_i] <= value_i;
      end
      // clear every sum as the final row is loaded into the output register
      if (cmd_i.emit_final) begin
        for (int r = 0; r < MAX_OUT; r++) begin
          sum_q[r] <= '0;
        end
      end else if (acc_en) begin
        sum_q[s2_row_q] <= sum_q[s2_row_q] + SUM_W'(prod_q);
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.s1_busy   = s1_vld_q;
  assign sts_o.pipe_busy = s1_vld_q || s2_vld_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign status_o    = status_q;

endmodule

// ----- design/gated_linear_layer_core.sv -----
// Gated fully connected layer: input item channel, result channel and register port.
// Each input item writes one weight, writes one row gate, or streams one vector
// element (signed Q3.12). An element is multiplied into the accumulator of every
// row 0..out_features-1 whose gate exceeds 0.5. On the element marked last, one
// result per row follows (row, Q15.24 sum, last-row flag, length status).
// Flow: for an element, the weight RAM read port serves one row per cycle, then
// the two-stage multiply and accumulate drains; no new item is taken before the
// drain ends. An element past in_features is taken without a multiply. After the
// last element, out_features results leave one per cycle while out_stall_i is low.
// Reset: the weight RAM is filled with 41 (about 0.01) in a clearing pass during
// which in_stall_o stays high; gates reset to 1.0, sums to zero, in_features to 64
// and out_features to 16. Registers may be written during that pass.
// A result waits in the output register while out_stall_i is high; emission holds,
// and the final result may still wait while the next item is taken.
// Registers: in_features at 0x0, out_features at 0x4.
module gated_linear_layer_core import gll_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              req_type_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [COL_W-1:0]        col_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ROW_W-1:0]        out_row_o,
  output logic signed [SUM_W-1:0] out_value_o,
  output logic                    out_last_o,
  output logic                    status_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [NIN_W-1:0]  in_features_q;
  logic [NOUT_W-1:0] out_features_q;
  logic [NIN_W-1:0]  n_in;
  logic [NOUT_W-1:0] n_out;
  logic              cfg_wr;
  gll_cmd_t          cmd;
  gll_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_features_q  <= NIN_W'(MAX_IN);
      out_features_q <= NOUT_W'(MAX_OUT);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IN_FEATURES:  in_features_q  <= pwdata[NIN_W-1:0];
        REG_OUT_FEATURES: out_features_q <= pwdata[NOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IN_FEATURES:  prdata = 32'(in_features_q);
      REG_OUT_FEATURES: prdata = 32'(out_features_q);
      default:          prdata = '0;
    endcase
  end

  // hold register values to the supported ranges
  assign n_in  = (in_features_q == '0) ? NIN_W'(1) :
                 (in_features_q > NIN_W'(MAX_IN)) ? NIN_W'(MAX_IN) : in_features_q;
  assign n_out = (out_features_q == '0) ? NOUT_W'(1) :
                 (out_features_q > NOUT_W'(MAX_OUT)) ? NOUT_W'(MAX_OUT) : out_features_q;

  gll_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .req_type_i(req_type_i),
    .last_i    (last_i),
    .n_in_i    (n_in),
    .n_out_i   (n_out),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  gll_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_i    (value_i),
    .out_stall_i(out_stall_i),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_row_o  (out_row_o),
    .out_value_o(out_value_o),
    .out_last_o (out_last_o),
    .status_o   (status_o)
  );

`ifndef SYNTH
  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_load |-> !sts.pipe_busy)
    else $error("result emitted while products are in flight");

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_load |-> sts.out_free)
    else $error("result overwrites a waiting transfer");

  a_issue_fills_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |=> sts.s1_busy)
    else $error("row issue did not enter the multiply pipeline");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.pipe_busy && !sts.s1_busy) |-> !(cmd.wr_weight || cmd.load_x) || !in_stall_o)
    else $error("item taken while the pipeline drains");
`endif

endmodule
